### rtl/iss_pkg.sv
`default_nettype none

package iss_pkg;

    localparam int KIND_W      = 3;
    localparam int POS_W       = 7;
    localparam int VAL_W       = 32;
    localparam int TOTAL_W     = 7;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [KIND_W-1:0] {
        REQ_INS_HEAD = 3'd0,
        REQ_INS_TAIL = 3'd1,
        REQ_INS_AT   = 3'd2,
        REQ_READ_AT  = 3'd3,
        REQ_DEL_HEAD = 3'd4,
        REQ_DEL_TAIL = 3'd5,
        REQ_DEL_AT   = 3'd6
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

endpackage

`default_nettype wire

### rtl/indexed_sequence_store_core.sv
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values kept packed at the low
// entries of a single-port-write, single-port-read memory. Each request gives
// exactly one response (status in m_axis_tuser, read value and new element
// count in m_axis_tdata). Inserting or deleting in the middle moves every later
// entry by one place, one entry per cycle through the memory read/write ports.
// An insert that moves entries passes through the shift, flush, put and done
// steps, a delete that moves entries through shift, flush and done; an insert at
// the end goes through put and done, a read through read and done, and a rejected
// request, an unused kind or a delete that moves nothing straight to done. The
// done step waits while the previous response still sits unaccepted in the output
// register. A new request is taken while a previous response still waits in the
// output register.
module indexed_sequence_store_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // position [6:0], item_value [38:7], zero [39]
    input  wire logic [iss_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // req_type [2:0]
    input  wire logic [iss_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // read_value [31:0], element_total [38:32], zero [39]
    output logic [iss_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // status [1:0]
    output logic [iss_pkg::STATUS_W-1:0]            m_axis_tuser
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > iss_pkg::POS_W) ? CW : iss_pkg::POS_W;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);
    localparam int PAD_W = iss_pkg::OUT_TDATA_W - iss_pkg::VAL_W - iss_pkg::TOTAL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_FLUSH,
        S_PUT,
        S_READ,
        S_DONE
    } state_t;

    state_t                      state_reg;
    logic [CW-1:0]               count_reg;
    logic [AW-1:0]               idx_reg;
    logic [AW-1:0]               end_reg;
    logic [AW-1:0]               wr_addr_reg;
    logic [AW-1:0]               pos_reg;
    logic                        pend_reg;
    logic                        down_reg;
    logic                        ins_reg;
    logic                        rd_reg;
    logic [iss_pkg::VAL_W-1:0]   value_reg;
    iss_pkg::status_t            status_reg;
    logic [iss_pkg::VAL_W-1:0]   rdata_reg;
    logic                        m_tvalid_reg;
    logic [iss_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic [iss_pkg::STATUS_W-1:0]    m_tuser_reg;

    logic [iss_pkg::VAL_W-1:0]   mem [CAPACITY];

    logic                        s_accept;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [iss_pkg::VAL_W-1:0]   mem_wdata;

    iss_pkg::req_kind_t          req_kind;
    logic [XW-1:0]               pos_x;
    logic [XW-1:0]               cnt_x;
    logic [XW-1:0]               d_ep;
    logic [XW-1:0]               d_start;
    logic [XW-1:0]               d_end;
    logic [XW-1:0]               d_cnt_next;
    iss_pkg::status_t            d_status;
    logic                        d_ins;
    logic                        d_rd;
    logic                        d_shift;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    assign req_kind = iss_pkg::req_kind_t'(s_axis_tuser);
    assign pos_x    = XW'(s_axis_tdata[iss_pkg::POS_W-1:0]);
    assign cnt_x    = XW'(count_reg);

    // request decode and range checks against the current count
    always_comb begin
        d_ep       = '0;
        d_start    = '0;
        d_end      = '0;
        d_cnt_next = cnt_x;
        d_status   = iss_pkg::ST_OK;
        d_ins      = 1'b0;
        d_rd       = 1'b0;
        d_shift    = 1'b0;
        unique case (req_kind)
            iss_pkg::REQ_INS_HEAD, iss_pkg::REQ_INS_TAIL, iss_pkg::REQ_INS_AT: begin
                if (req_kind == iss_pkg::REQ_INS_HEAD) begin
                    d_ep = '0;
                end else if (req_kind == iss_pkg::REQ_INS_TAIL) begin
                    d_ep = cnt_x;
                end else begin
                    d_ep = pos_x;
                end
                if (d_ep > cnt_x) begin
                    d_status = iss_pkg::ST_BADPOS;
                end else if (cnt_x == CAP_X) begin
                    d_status = iss_pkg::ST_FULL;
                end else begin
                    d_ins      = 1'b1;
                    d_shift    = (d_ep < cnt_x);
                    d_start    = cnt_x - XW'(1);
                    d_end      = d_ep;
                    d_cnt_next = cnt_x + XW'(1);
                end
            end
            iss_pkg::REQ_READ_AT: begin
                d_ep = pos_x;
                if (d_ep < cnt_x) begin
                    d_rd = 1'b1;
                end else begin
                    d_status = iss_pkg::ST_BADPOS;
                end
            end
            iss_pkg::REQ_DEL_HEAD, iss_pkg::REQ_DEL_TAIL, iss_pkg::REQ_DEL_AT: begin
                if (req_kind == iss_pkg::REQ_DEL_HEAD) begin
                    d_ep = '0;
                end else if (req_kind == iss_pkg::REQ_DEL_TAIL) begin
                    d_ep = cnt_x - XW'(1);
                end else begin
                    d_ep = pos_x;
                end
                if (cnt_x == '0) begin
                    d_status = iss_pkg::ST_EMPTY;
                end else if (req_kind == iss_pkg::REQ_DEL_AT && d_ep >= cnt_x) begin
                    d_status = iss_pkg::ST_BADPOS;
                end else begin
                    d_shift    = (d_ep + XW'(1) < cnt_x);
                    d_start    = d_ep + XW'(1);
                    d_end      = cnt_x - XW'(1);
                    d_cnt_next = cnt_x - XW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // write port: moved entry while shifting, or the new value
    always_comb begin
        mem_we    = ((state_reg == S_SHIFT) && pend_reg) || (state_reg == S_FLUSH)
                    || (state_reg == S_PUT);
        mem_waddr = (state_reg == S_PUT) ? pos_reg : wr_addr_reg;
        mem_wdata = (state_reg == S_PUT) ? value_reg : rdata_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // the done step reloads the output register itself
            if (m_tvalid_reg && m_axis_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        count_reg  <= CW'(d_cnt_next);
                        status_reg <= d_status;
                        rd_reg     <= d_rd;
                        ins_reg    <= d_ins;
                        down_reg   <= d_ins;
                        pos_reg    <= AW'(d_ep);
                        value_reg  <= s_axis_tdata[iss_pkg::POS_W +: iss_pkg::VAL_W];
                        idx_reg    <= d_rd ? AW'(d_ep) : AW'(d_start);
                        end_reg    <= AW'(d_end);
                        pend_reg   <= 1'b0;
                        if (d_shift) begin
                            state_reg <= S_SHIFT;
                        end else if (d_ins) begin
                            state_reg <= S_PUT;
                        end else if (d_rd) begin
                            state_reg <= S_READ;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SHIFT: begin
                    // entry read this cycle lands one place up (insert) or down (delete)
                    pend_reg    <= 1'b1;
                    wr_addr_reg <= down_reg ? idx_reg + AW'(1) : idx_reg - AW'(1);
                    if (idx_reg == end_reg) begin
                        state_reg <= S_FLUSH;
                    end else begin
                        idx_reg <= down_reg ? idx_reg - AW'(1) : idx_reg + AW'(1);
                    end
                end
                S_FLUSH: begin
                    pend_reg  <= 1'b0;
                    state_reg <= ins_reg ? S_PUT : S_DONE;
                end
                S_PUT: begin
                    state_reg <= S_DONE;
                end
                S_READ: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_axis_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= status_reg;
                        m_tdata_reg  <= {{PAD_W{1'b0}},
                                         iss_pkg::TOTAL_W'(count_reg),
                                         rd_reg ? rdata_reg : '0};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_axis_tready)
        else $error("ready right after an accepted request");

    a_count_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(count_reg))
        else $error("count changed without a request");

    a_write_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !s_axis_tready)
        else $error("memory write while idle");

    a_response_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("response loaded outside the done step");

endmodule

`default_nettype wire

### tb/sv/tb.sv
module tb;
    import iss_pkg::*;

    localparam int CAPACITY = 64;
    localparam logic [KIND_W-1:0] REQ_UNUSED = 3'd7;

    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   read_value;
        logic [TOTAL_W-1:0] element_total;
    } outcome_t;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic [KIND_W-1:0]         s_axis_tuser  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;
    logic [STATUS_W-1:0]       m_axis_tuser;

    // mirror of the list contents and length
    logic [VAL_W-1:0] list_mem [CAPACITY];
    int               list_len = 0;
    outcome_t         pending_results [$];
    int               fail_count = 0;
    int               src_idle_pct = 0;
    int               sink_idle_pct = 0;

    indexed_sequence_store_core #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic outcome_t apply_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                               logic [VAL_W-1:0] value);
        outcome_t r;
        int       at;
        r.status     = ST_OK;
        r.read_value = '0;
        case (kind)
            REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_AT: begin
                at = (kind == REQ_INS_HEAD) ? 0 : (kind == REQ_INS_TAIL) ? list_len : int'(pos);
                // position check comes before the full check
                if (at > list_len) begin
                    r.status = ST_BADPOS;
                end else if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
                    list_mem[at] = value;
                    list_len++;
                end
            end
            REQ_READ_AT: begin
                if (int'(pos) < list_len) r.read_value = list_mem[pos];
                else r.status = ST_BADPOS;
            end
            REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_AT: begin
                at = (kind == REQ_DEL_HEAD) ? 0 : (kind == REQ_DEL_TAIL) ? list_len - 1 : int'(pos);
                // empty check comes before the position check
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (at >= list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (int i = at; i < list_len - 1; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            default: ;
        endcase
        r.element_total = list_len[TOTAL_W-1:0];
        return r;
    endfunction

    task automatic send_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                logic [VAL_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, value, pos};
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(apply_request(kind, pos, value));
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : check_responses
        outcome_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("response with no request outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[VAL_W-1:0] !== want.read_value) begin
                    $error("read_value expected %0d got %0d", $signed(want.read_value),
                           $signed(m_axis_tdata[VAL_W-1:0]));
                    fail_count++;
                end
                if (m_axis_tdata[VAL_W+TOTAL_W-1:VAL_W] !== want.element_total) begin
                    $error("element_total expected %0d got %0d", want.element_total,
                           m_axis_tdata[VAL_W+TOTAL_W-1:VAL_W]);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_empty_list();
        send_request(REQ_DEL_HEAD, 7'd0, 32'h0);
        send_request(REQ_DEL_TAIL, 7'd0, 32'h0);
        send_request(REQ_DEL_AT, 7'd0, 32'h0);
        send_request(REQ_READ_AT, 7'd0, 32'h0);
        send_request(REQ_INS_AT, 7'd1, 32'h1234_5678);
        send_request(REQ_UNUSED, 7'd127, 32'hffff_ffff);
    endtask

    task automatic test_head_tail();
        send_request(REQ_INS_HEAD, 7'd0, 32'h7fff_ffff);
        send_request(REQ_INS_TAIL, 7'd0, 32'h8000_0000);
        send_request(REQ_INS_HEAD, 7'd0, 32'h0000_0000);
        send_request(REQ_INS_TAIL, 7'd0, 32'hffff_ffff);
        for (int i = 0; i < 4; i++) send_request(REQ_READ_AT, 7'(i), 32'h0);
    endtask

    task automatic test_positional();
        send_request(REQ_INS_AT, 7'd2, 32'h5555_5555);
        send_request(REQ_INS_AT, 7'd5, 32'haaaa_aaaa);
        send_request(REQ_INS_AT, 7'd7, 32'h0bad_0bad);
        send_request(REQ_READ_AT, 7'd2, 32'h0);
        send_request(REQ_READ_AT, 7'd127, 32'h0);
        send_request(REQ_DEL_AT, 7'd127, 32'h0);
        send_request(REQ_DEL_AT, 7'd1, 32'h0);
        send_request(REQ_DEL_TAIL, 7'd0, 32'h0);
        send_request(REQ_DEL_HEAD, 7'd0, 32'h0);
        send_request(REQ_READ_AT, 7'd0, 32'h0);
    endtask

    // alternating fill and drain blocks push the list to full and back to empty
    task automatic test_random_traffic(int n_items, int src_pct, int sink_pct);
        int               r;
        int               ins_share;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  value;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int n = 0; n < n_items; n++) begin
            if (n % 200 == 0 && n != 0) wait_results_drained();
            ins_share = ((n / 200) % 2 == 0) ? 70 : 20;
            r = $urandom_range(99);
            if (r < 3) kind = REQ_UNUSED;
            else if (r < ins_share) kind = 3'($urandom_range(2));
            else if (r < ins_share + 12) kind = REQ_READ_AT;
            else kind = 3'($urandom_range(6, 4));
            if ($urandom_range(99) < 15) pos = 7'($urandom_range(127));
            else if (kind <= REQ_INS_AT) pos = 7'($urandom_range(list_len));
            else pos = 7'($urandom_range(list_len == 0 ? 0 : list_len - 1));
            case ($urandom_range(19))
                0: value = 32'h8000_0000;
                1: value = 32'h7fff_ffff;
                2: value = 32'hffff_ffff;
                default: value = $urandom;
            endcase
            send_request(kind, pos, value);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        src_idle_pct  = 30;
        sink_idle_pct = 55;
        test_empty_list();
        test_head_tail();
        test_positional();
        test_random_traffic(630, 30, 55);
        test_random_traffic(630, 55, 30);
        test_random_traffic(630, 0, 0);

        wait_results_drained();
        repeat (CAPACITY + 8) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
rtl/iss_pkg.sv
rtl/indexed_sequence_store_core.sv
tb/sv/tb.sv
